@@ rtl/regularized_sym3x3_inverse_assert.svh @@
// Assertion macros for the regularized 3x3 inverse block.
`ifndef REGULARIZED_SYM3X3_INVERSE_ASSERT_SVH
`define REGULARIZED_SYM3X3_INVERSE_ASSERT_SVH

// Consequent checked in the same cycle.
`define RSI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsi assertion failed");

// Consequent checked in the next cycle.
`define RSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsi assertion failed");

`endif

@@ rtl/rsi_pkg.sv @@
// Types and constants of the regularized 3x3 inverse block.
`timescale 1ns / 1ps
package rsi_pkg;

    localparam int MW       = 34;   // covariance term plus epsilon
    localparam int PW       = 68;   // products and adjugate terms
    localparam int LW       = 35;   // low slice of an adjugate term, signed
    localparam int SPLIT    = 34;
    localparam int DW       = 104;  // determinant
    localparam int NW       = 122;  // scaled numerator
    localparam int QW       = 49;   // quotient bits incl. one guard bit
    localparam int OW       = 48;
    localparam int CW       = DW + QW;
    localparam int FRAC_SH  = 54;
    localparam int LANES    = 6;
    localparam int ADDR_W   = 3;

    localparam logic [30:0]   EPS_RESET = 31'd3221;
    localparam logic          REG_EPSILON = 1'b0;
    localparam logic [OW-1:0] LIM_POS = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] LIM_NEG = {1'b1, {(OW-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SAT      = 2'd1,
        ST_SINGULAR = 2'd2
    } status_t;

    typedef logic signed [MW-1:0] mat_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [DW-1:0] det_t;

endpackage

@@ rtl/regularized_sym3x3_inverse.sv @@
// Regularized symmetric 3x3 inverse: top level with full datapath pipeline.
`timescale 1ns / 1ps
// Usage:
//   Input channel: in_valid / in_stall with cov_00..cov_22 (signed Q1.30) and
//   last_pixel. A beat is taken on a clock edge with in_valid high and in_stall
//   low. Output channel: out_valid / out_stall with inv_00..inv_22 (signed
//   Q23.24), status and last_out.
//   epsilon is to be written over the APB port at address 0 only while the
//   block is idle; the block itself does not enforce this. It is added to
//   the three diagonal terms of every beat. Throughput: one beat per cycle
//   while the receiver does not stall. Six lanes of restoring division, one
//   quotient bit per pipeline stage over 49 stages, sit behind six stages of
//   epsilon add, products, adjugate, determinant and setup.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits and loads epsilon with 3221 (about 3.0e-6).
`include "regularized_sym3x3_inverse_assert.svh"

module regularized_sym3x3_inverse (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rsi_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [31:0]         cov_00,
    input  logic signed [31:0]         cov_01,
    input  logic signed [31:0]         cov_02,
    input  logic signed [31:0]         cov_11,
    input  logic signed [31:0]         cov_12,
    input  logic signed [31:0]         cov_22,
    input  logic                       last_pixel,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [47:0]         inv_00,
    output logic signed [47:0]         inv_01,
    output logic signed [47:0]         inv_02,
    output logic signed [47:0]         inv_11,
    output logic signed [47:0]         inv_12,
    output logic signed [47:0]         inv_22,
    output logic [1:0]                 status,
    output logic                       last_out
);

    localparam int MW = rsi_pkg::MW;
    localparam int PW = rsi_pkg::PW;
    localparam int LW = rsi_pkg::LW;
    localparam int DW = rsi_pkg::DW;
    localparam int NW = rsi_pkg::NW;
    localparam int QW = rsi_pkg::QW;
    localparam int OW = rsi_pkg::OW;
    localparam int CW = rsi_pkg::CW;
    localparam int NL = rsi_pkg::LANES;

    // ---------------- configuration ----------------
    logic [30:0] eps_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= rsi_pkg::EPS_RESET;
        end
        else if (cfg_wr && paddr[2] == rsi_pkg::REG_EPSILON)
        begin
            eps_reg <= pwdata[30:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == rsi_pkg::REG_EPSILON)
        begin
            prdata = {1'b0, eps_reg};
        end
    end

    // ---------------- flow control ----------------
    logic out_valid_reg;
    logic adv;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // ---------------- stage A: epsilon add ----------------
    rsi_pkg::mat_t ma_reg [0:5];
    rsi_pkg::mat_t ma_next [0:5];
    logic          la_reg, va_reg;
    rsi_pkg::mat_t eps_m;

    always_comb
    begin
        eps_m      = rsi_pkg::mat_t'({1'b0, eps_reg});
        ma_next[0] = rsi_pkg::mat_t'(cov_00) + eps_m;
        ma_next[1] = rsi_pkg::mat_t'(cov_01);
        ma_next[2] = rsi_pkg::mat_t'(cov_02);
        ma_next[3] = rsi_pkg::mat_t'(cov_11) + eps_m;
        ma_next[4] = rsi_pkg::mat_t'(cov_12);
        ma_next[5] = rsi_pkg::mat_t'(cov_22) + eps_m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ma_reg <= ma_next;
            la_reg <= last_pixel;
        end
    end

    // ---------------- stage B: twelve products ----------------
    rsi_pkg::prod_t pb_reg [0:11];
    rsi_pkg::prod_t pb_next [0:11];
    rsi_pkg::mat_t  mb_reg [0:2];
    logic           lb_reg, vb_reg;

    // ma index: 0=m00 1=m01 2=m02 3=m11 4=m12 5=m22
    always_comb
    begin
        pb_next[0]  = ma_reg[3] * ma_reg[5];
        pb_next[1]  = ma_reg[4] * ma_reg[4];
        pb_next[2]  = ma_reg[2] * ma_reg[4];
        pb_next[3]  = ma_reg[1] * ma_reg[5];
        pb_next[4]  = ma_reg[1] * ma_reg[4];
        pb_next[5]  = ma_reg[2] * ma_reg[3];
        pb_next[6]  = ma_reg[0] * ma_reg[5];
        pb_next[7]  = ma_reg[2] * ma_reg[2];
        pb_next[8]  = ma_reg[1] * ma_reg[2];
        pb_next[9]  = ma_reg[0] * ma_reg[4];
        pb_next[10] = ma_reg[0] * ma_reg[3];
        pb_next[11] = ma_reg[1] * ma_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pb_reg    <= pb_next;
            mb_reg[0] <= ma_reg[0];
            mb_reg[1] <= ma_reg[1];
            mb_reg[2] <= ma_reg[2];
            lb_reg    <= la_reg;
        end
    end

    // ---------------- stage C: adjugate ----------------
    rsi_pkg::prod_t adjc_reg [0:5];
    rsi_pkg::prod_t adjc_next [0:5];
    rsi_pkg::mat_t  mc_reg [0:2];
    logic           lc_reg, vc_reg;

    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            adjc_next[k] = pb_reg[2*k] - pb_reg[2*k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            adjc_reg <= adjc_next;
            mc_reg   <= mb_reg;
            lc_reg   <= lb_reg;
        end
    end

    // ---------------- stage D: determinant partial products ----------------
    logic signed [LW+MW-1:0] plo_reg [0:2];
    logic signed [LW+MW-1:0] plo_next [0:2];
    rsi_pkg::prod_t          phi_reg [0:2];
    rsi_pkg::prod_t          phi_next [0:2];
    rsi_pkg::prod_t          adjd_reg [0:5];
    logic                    ld_reg, vd_reg;
    logic signed [LW-1:0]    adj_lo [0:2];
    rsi_pkg::mat_t           adj_hi [0:2];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            adj_lo[k]   = {1'b0, adjc_reg[k][rsi_pkg::SPLIT-1:0]};
            adj_hi[k]   = adjc_reg[k][PW-1:rsi_pkg::SPLIT];
            plo_next[k] = adj_lo[k] * mc_reg[k];
            phi_next[k] = adj_hi[k] * mc_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
        end
        else if (adv)
        begin
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            adjd_reg <= adjc_reg;
            ld_reg   <= lc_reg;
        end
    end

    // ---------------- stage E: determinant sum ----------------
    rsi_pkg::det_t  dete_reg;
    rsi_pkg::det_t  dete_next;
    rsi_pkg::prod_t adje_reg [0:5];
    logic           le_reg, ve_reg;

    always_comb
    begin
        dete_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            dete_next = dete_next + (rsi_pkg::det_t'(phi_reg[k]) <<< rsi_pkg::SPLIT)
                      + rsi_pkg::det_t'(plo_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
        end
        else if (adv)
        begin
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dete_reg <= dete_next;
            adje_reg <= adjd_reg;
            le_reg   <= ld_reg;
        end
    end

    // ---------------- divider: setup (index 0) and one bit per stage ----------------
    logic [NW-1:0] rem_reg  [0:QW][0:5];
    logic [QW-1:0] q_reg    [0:QW][0:5];
    logic          neg_reg  [0:QW][0:5];
    logic          ovf_reg  [0:QW][0:5];
    logic [DW-1:0] d_reg    [0:QW];
    logic          zero_reg [0:QW];
    logic          last_reg [0:QW];
    logic          vld_reg  [0:QW];

    logic [DW-1:0] dmag_next;
    logic [PW-1:0] amag      [0:5];
    logic [NW-1:0] n_next    [0:5];
    logic          neg_next  [0:5];
    logic          ovf_next  [0:5];

    // numerator carries the half-divisor so truncation rounds half away from zero
    always_comb
    begin
        dmag_next = dete_reg[DW-1] ? DW'(-dete_reg) : DW'(dete_reg);
        for (int k = 0; k < NL; k++)
        begin
            amag[k]     = adje_reg[k][PW-1] ? PW'(-adje_reg[k]) : PW'(adje_reg[k]);
            n_next[k]   = (NW'(amag[k]) << rsi_pkg::FRAC_SH) + NW'(dmag_next >> 1);
            neg_next[k] = adje_reg[k][PW-1] ^ dete_reg[DW-1];
            ovf_next[k] = CW'(n_next[k]) >= (CW'(dmag_next) << QW);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NL; k++)
            begin
                rem_reg[0][k] <= n_next[k];
                q_reg[0][k]   <= '0;
                neg_reg[0][k] <= neg_next[k];
                ovf_reg[0][k] <= ovf_next[k];
            end
            d_reg[0]    <= dmag_next;
            zero_reg[0] <= (dete_reg == '0);
            last_reg[0] <= le_reg;
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        localparam int SH = QW - j;
        logic [NW-1:0] rem_next [0:5];
        logic          ge_next  [0:5];
        logic [CW-1:0] dsh;

        always_comb
        begin
            dsh = CW'(d_reg[j-1]) << SH;
            for (int k = 0; k < NL; k++)
            begin
                ge_next[k]  = CW'(rem_reg[j-1][k]) >= dsh;
                rem_next[k] = ge_next[k] ? NW'(CW'(rem_reg[j-1][k]) - dsh)
                                         : rem_reg[j-1][k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int k = 0; k < NL; k++)
                begin
                    rem_reg[j][k] <= rem_next[k];
                    q_reg[j][k]   <= {q_reg[j-1][k][QW-2:0], ge_next[k]};
                    neg_reg[j][k] <= neg_reg[j-1][k];
                    ovf_reg[j][k] <= ovf_reg[j-1][k];
                end
                d_reg[j]    <= d_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                last_reg[j] <= last_reg[j-1];
            end
        end
    end

    // ---------------- output stage: saturate, sign, status ----------------
    logic signed [OW-1:0] inv_reg  [0:5];
    logic signed [OW-1:0] inv_next [0:5];
    rsi_pkg::status_t     status_reg, status_next;
    logic                 last_out_reg;
    logic [OW-1:0]        lim      [0:5];
    logic [OW-1:0]        qc       [0:5];
    logic                 sat      [0:5];
    logic                 any_sat;

    always_comb
    begin
        any_sat = 1'b0;
        for (int k = 0; k < NL; k++)
        begin
            lim[k] = neg_reg[QW][k] ? rsi_pkg::LIM_NEG : rsi_pkg::LIM_POS;
            sat[k] = ovf_reg[QW][k] || (q_reg[QW][k] > QW'(lim[k]));
            qc[k]  = sat[k] ? lim[k] : q_reg[QW][k][OW-1:0];
            inv_next[k] = neg_reg[QW][k] ? OW'(-qc[k]) : qc[k];
            any_sat = any_sat | sat[k];
            if (zero_reg[QW])
            begin
                inv_next[k] = '0;
            end
        end
        if (zero_reg[QW])
        begin
            status_next = rsi_pkg::ST_SINGULAR;
        end
        else if (any_sat)
        begin
            status_next = rsi_pkg::ST_SAT;
        end
        else
        begin
            status_next = rsi_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inv_reg      <= inv_next;
            status_reg   <= status_next;
            last_out_reg <= last_reg[QW];
        end
    end

    assign out_valid = out_valid_reg;
    assign inv_00    = inv_reg[0];
    assign inv_01    = inv_reg[1];
    assign inv_02    = inv_reg[2];
    assign inv_11    = inv_reg[3];
    assign inv_12    = inv_reg[4];
    assign inv_22    = inv_reg[5];
    assign status    = status_reg;
    assign last_out  = last_out_reg;

    // ---------------- assertions ----------------
    `RSI_ASSERT_SAME(a_singular_zero, out_valid && status == rsi_pkg::ST_SINGULAR, inv_00 == '0 && inv_01 == '0 && inv_02 == '0 && inv_11 == '0 && inv_12 == '0 && inv_22 == '0)
    `RSI_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)
    `RSI_ASSERT_NEXT(a_pipe_hold, in_stall && vld_reg[QW], vld_reg[QW] && out_valid)
    `RSI_ASSERT_SAME(a_status_code, out_valid, status == rsi_pkg::ST_OK || status == rsi_pkg::ST_SAT || status == rsi_pkg::ST_SINGULAR)

endmodule

@@ verif/tb.sv @@
// Testbench for the regularized symmetric 3x3 inverse block.
`timescale 1ns / 1ps

class inverse_scoreboard;
    typedef struct {
        logic signed [47:0] term [6];
        rsi_pkg::status_t   st;
        logic               last;
    } inv_result_t;

    inv_result_t pending[$];
    logic [30:0] eps;
    int          mismatches;

    function new();
        eps = rsi_pkg::EPS_RESET;
        mismatches = 0;
    endfunction

    // exact adj * 2^54 / det, nearest with ties away from zero, clamped to 48 bits
    function automatic logic signed [47:0] scaled_quotient(logic signed [127:0] adj,
            logic signed [127:0] det, ref bit sat);
        logic [255:0] n;
        logic [255:0] d;
        logic [255:0] q;
        bit           neg;
        neg = adj[127] ^ det[127];
        n = adj[127] ? -adj : adj;
        d = det[127] ? -det : det;
        n = (n << 54) + (d >> 1);
        q = n / d;
        if (!neg && q > 256'h7FFF_FFFF_FFFF) begin
            sat = 1'b1;
            return 48'h7FFF_FFFF_FFFF;
        end
        if (neg && q > 256'h8000_0000_0000) begin
            sat = 1'b1;
            return 48'h8000_0000_0000;
        end
        return neg ? -q[47:0] : q[47:0];
    endfunction

    function automatic void note_pixel(logic signed [31:0] c [6], logic lp);
        logic signed [127:0] m00, m01, m02, m11, m12, m22, det;
        logic signed [127:0] adj [6];
        inv_result_t r;
        bit sat;
        m00 = c[0] + $signed({1'b0, eps});
        m01 = c[1];
        m02 = c[2];
        m11 = c[3] + $signed({1'b0, eps});
        m12 = c[4];
        m22 = c[5] + $signed({1'b0, eps});
        adj[0] = m11 * m22 - m12 * m12;
        adj[1] = m02 * m12 - m01 * m22;
        adj[2] = m01 * m12 - m02 * m11;
        adj[3] = m00 * m22 - m02 * m02;
        adj[4] = m01 * m02 - m00 * m12;
        adj[5] = m00 * m11 - m01 * m01;
        det = adj[0] * m00 + adj[1] * m01 + adj[2] * m02;
        sat = 1'b0;
        if (det == 0) begin
            foreach (r.term[k]) r.term[k] = '0;
            r.st = rsi_pkg::ST_SINGULAR;
        end else begin
            foreach (r.term[k]) r.term[k] = scaled_quotient(adj[k], det, sat);
            r.st = sat ? rsi_pkg::ST_SAT : rsi_pkg::ST_OK;
        end
        r.last = lp;
        pending.push_back(r);
    endfunction

    function automatic void check_result(logic signed [47:0] t [6], logic [1:0] st,
            logic lo);
        inv_result_t e;
        bit bad;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat");
            return;
        end
        e = pending.pop_front();
        bad = (st !== e.st) || (lo !== e.last);
        foreach (t[k]) if (t[k] !== e.term[k]) bad = 1'b1;
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: exp st=%0d last=%0d inv=%h %h %h %h %h %h",
                    e.st, e.last, e.term[0], e.term[1], e.term[2], e.term[3],
                    e.term[4], e.term[5]);
                $display("          got st=%0d last=%0d inv=%h %h %h %h %h %h",
                    st, lo, t[0], t[1], t[2], t[3], t[4], t[5]);
            end
        end
    endfunction
endclass

module tb;

    localparam int LATENCY   = 56;
    localparam int MAX_CYCLE = 400000;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [rsi_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_stall, out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] cov [6];
    logic last_pixel;
    logic signed [47:0] inv [6];
    logic [1:0] status;
    logic last_out;

    inverse_scoreboard sb;
    bit   quiet_idle;
    int   cycle;

    regularized_sym3x3_inverse u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .cov_00(cov[0]), .cov_01(cov[1]), .cov_02(cov[2]),
        .cov_11(cov[3]), .cov_12(cov[4]), .cov_22(cov[5]),
        .last_pixel(last_pixel),
        .out_valid(out_valid), .out_stall(out_stall),
        .inv_00(inv[0]), .inv_01(inv[1]), .inv_02(inv[2]),
        .inv_11(inv[3]), .inv_12(inv[4]), .inv_22(inv[5]),
        .status(status), .last_out(last_out)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle = 0;
        forever begin
            @(posedge clk);
            cycle++;
            if (cycle > MAX_CYCLE) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: random stall, check on accepted beats
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(inv, status, last_out);
        out_stall <= quiet_idle ? 1'b0 : ($urandom_range(99) < 11);
    end

    task automatic write_epsilon(logic [30:0] v);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= rsi_pkg::ADDR_W'(rsi_pkg::REG_EPSILON) << 2; pwdata <= {1'b0, v};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.eps = v;
    endtask

    // in_valid stays high between back-to-back beats; an idle cycle drops it
    task automatic send_pixel(logic signed [31:0] c [6], logic lp);
        if (!quiet_idle)
            while ($urandom_range(99) < 11) begin
                in_valid <= 0;
                @(posedge clk);
            end
        for (int k = 0; k < 6; k++) cov[k] <= c[k];
        last_pixel <= lp;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        sb.note_pixel(c, lp);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic random_pixels(int n);
        logic signed [31:0] c [6];
        logic signed [31:0] s;
        for (int i = 0; i < n; i++) begin
            quiet_idle = (i % 250) >= 170;
            s = $urandom;
            case ($urandom_range(5))
                0: foreach (c[k]) c[k] = $urandom;
                1: begin // positive definite-ish covariance, small off-diagonals
                    c[0] = $urandom_range(32'h3FFF_FFFF);
                    c[3] = $urandom_range(32'h3FFF_FFFF);
                    c[5] = $urandom_range(32'h3FFF_FFFF);
                    c[1] = $signed($urandom) >>> $urandom_range(31, 2);
                    c[2] = $signed($urandom) >>> $urandom_range(31, 2);
                    c[4] = $signed($urandom) >>> $urandom_range(31, 2);
                end
                2: foreach (c[k]) c[k] = $signed($urandom) >>> $urandom_range(31, 20);
                3: begin // rank-deficient: rows equal
                    c[0] = s; c[1] = s; c[2] = s; c[3] = s; c[4] = s; c[5] = s;
                end
                4: begin
                    foreach (c[k]) c[k] = 0;
                    c[0] = $urandom; c[3] = $urandom; c[5] = $urandom;
                end
                default: foreach (c[k]) c[k] = $signed($urandom) >>> $urandom_range(31, 0);
            endcase
            send_pixel(c, 1'($urandom_range(1)));
        end
        quiet_idle = 0;
    endtask

    initial begin
        logic signed [31:0] c [6];
        sb = new();
        quiet_idle = 0;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; last_pixel = 0;
        foreach (cov[k]) cov[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // directed: reset epsilon
        foreach (c[k]) c[k] = 0;
        send_pixel(c, 1'b0);                        // epsilon-only diagonal
        c = '{32'h4000_0000, 0, 0, 32'h4000_0000, 0, 32'h4000_0000};
        send_pixel(c, 1'b1);                        // identity
        foreach (c[k]) c[k] = 32'h7FFF_FFFF;
        send_pixel(c, 1'b0);
        foreach (c[k]) c[k] = 32'h8000_0000;
        send_pixel(c, 1'b1);
        c = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        send_pixel(c, 1'b0);
        c = '{-3221, 0, 0, 32'h1000, 0, 32'h1000};  // det zero with epsilon
        send_pixel(c, 1'b0);
        c = '{32'hFFFF_FFFF, 1, -1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF};
        send_pixel(c, 1'b1);
        drain();

        write_epsilon('0);
        foreach (c[k]) c[k] = 0;
        send_pixel(c, 1'b0);                        // singular
        c = '{1, 0, 0, 1, 0, 1};
        send_pixel(c, 1'b1);                        // saturates
        c = '{32'h4000_0000, 32'h4000_0000, 0, 32'h4000_0000, 0, 32'h4000_0000};
        send_pixel(c, 1'b0);
        c = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
              32'hEDCB_A987, 32'h0F0F_0F0F, 32'hF0F0_F0F0};
        send_pixel(c, 1'b1);
        random_pixels(150);
        drain();

        write_epsilon(31'h7FFF_FFFF);
        foreach (c[k]) c[k] = 32'h8000_0001;
        send_pixel(c, 1'b0);
        random_pixels(150);
        drain();

        write_epsilon(31'h0000_0C95);
        random_pixels(250);
        drain();

        write_epsilon(31'($urandom));
        random_pixels(180);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/rsi_pkg.sv
rtl/regularized_sym3x3_inverse.sv
verif/tb.sv
